// ===== rtl/fpsc_pkg.sv =====
// shared widths, register indexes and control structs for the fitch site combiner
package fpsc_pkg;

   localparam int SET_W      = 5;
   localparam int GAP_IDX    = 4;
   localparam int WEIGHT_W   = 32;
   localparam int OUT_COST_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_WEIGHTS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_GAP_RUNS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_MIXED_GAPS = 2'd2;

   typedef struct packed {
      logic use_weights;
      logic merge_gap_runs;
      logic strip_mixed_gaps;
   } cfg_type;

   typedef struct packed {
      logic first_site;
      logic prev_node_gap;
      logic prev_left_gap;
      logic prev_right_gap;
   } hist_type;

   localparam hist_type HIST_RESET = '{first_site: 1'b1, prev_node_gap: 1'b0,
                                       prev_left_gap: 1'b0, prev_right_gap: 1'b0};

endpackage

// ===== rtl/fpsc_if.sv =====
// valid/ready channel interfaces for site words and result words
interface fpsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [fpsc_pkg::SET_W-1:0]    left_set;
   logic [fpsc_pkg::SET_W-1:0]    right_set;
   logic [fpsc_pkg::WEIGHT_W-1:0] site_weight;
   logic                          last_site;

   modport source (output valid, left_set, right_set, site_weight, last_site,
                   input ready);
   modport sink (input valid, left_set, right_set, site_weight, last_site,
                 output ready);
endinterface

interface fpsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fpsc_pkg::SET_W-1:0]      node_set;
   logic                            mutation_counted;
   logic [fpsc_pkg::OUT_COST_W-1:0] total_cost;
   logic                            cost_final;

   modport source (output valid, node_set, mutation_counted, total_cost, cost_final,
                   input ready);
   modport sink (input valid, node_set, mutation_counted, total_cost, cost_final,
                 output ready);
endinterface

// ===== rtl/fitch_parsimony_site_combine.sv =====
// top level of the fitch parsimony site combiner: input stage, state and result stage
//
//   channel | dir | handshake     | word
//   req_ch  | in  | valid / ready | left_set, right_set, site_weight, last_site
//   rsp_ch  | out | valid / ready | node_set, mutation_counted, total_cost, cost_final
//   csr_*   | in  | write enable  | csr_index, csr_wdata (one bit)
//
// one word per cycle sustained while rsp_ch is ready; an accepted word is held in the input
// stage and then in the result stage before it shows on rsp_ch
// the evaluation between the input stage and the result stage reads and updates the
// gap history and the running cost in the same cycle, which sets the one-word-per-cycle rate
// reset clears both stage valids, the gap history and the cost; config regs reload
// a stall on rsp_ch holds the result stage and backs up into the input stage
module fitch_parsimony_site_combine #(
   parameter int COST_BITS = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   fpsc_req_if.sink                        req_ch,
   fpsc_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [fpsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpsc_pkg::*;

   cfg_type cfg;

   logic                  in_valid_ff;
   logic [SET_W-1:0]      left_ff;
   logic [SET_W-1:0]      right_ff;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic                  last_ff;

   hist_type              hist_ff;
   hist_type              hist_in;
   logic [COST_BITS-1:0]  cost_ff;
   logic [COST_BITS-1:0]  cost_in;

   logic                  out_valid_ff;
   logic [SET_W-1:0]      node_ff;
   logic                  counted_ff;
   logic [OUT_COST_W-1:0] total_ff;
   logic                  final_ff;

   logic [SET_W-1:0]      node_in;
   logic                  counted_in;
   logic [OUT_COST_W-1:0] total_in;

   logic out_free;
   logic advance;
   logic req_take;

   fpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpsc_site_eval #(
      .COST_BITS (COST_BITS)
   ) u_eval (
      .cfg              (cfg),
      .hist             (hist_ff),
      .cost             (cost_ff),
      .left_set         (left_ff),
      .right_set        (right_ff),
      .site_weight      (weight_ff),
      .last_site        (last_ff),
      .node_set         (node_in),
      .mutation_counted (counted_in),
      .total_cost       (total_in),
      .cost_next        (cost_in),
      .hist_next        (hist_in)
   );

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= HIST_RESET;
         cost_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            hist_ff <= hist_in;
            cost_ff <= cost_in;
         end
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         left_ff   <= req_ch.left_set;
         right_ff  <= req_ch.right_set;
         weight_ff <= req_ch.site_weight;
         last_ff   <= req_ch.last_site;
      end
      if (advance) begin
         node_ff    <= node_in;
         counted_ff <= counted_in;
         total_ff   <= total_in;
         final_ff   <= last_ff;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.node_set         = node_ff;
   assign rsp_ch.mutation_counted = counted_ff;
   assign rsp_ch.total_cost       = total_ff;
   assign rsp_ch.cost_final       = final_ff;

endmodule

// ===== rtl/fpsc_csr.sv =====
// configuration registers of the fitch site combiner
module fpsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fpsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fpsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output fpsc_pkg::cfg_type                 cfg
);
   import fpsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_USE_WEIGHTS:      cfg_in.use_weights      = csr_wdata[0];
            CSR_MERGE_GAP_RUNS:   cfg_in.merge_gap_runs   = csr_wdata[0];
            CSR_STRIP_MIXED_GAPS: cfg_in.strip_mixed_gaps = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_weights: 1'b0, merge_gap_runs: 1'b1, strip_mixed_gaps: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fpsc_site_eval.sv =====
// combinational fitch step: parent set, gap rules and saturating cost add
module fpsc_site_eval #(
   parameter int COST_BITS = 48
) (
   input  fpsc_pkg::cfg_type                 cfg,
   input  fpsc_pkg::hist_type                hist,
   input  logic [COST_BITS-1:0]              cost,
   input  logic [fpsc_pkg::SET_W-1:0]        left_set,
   input  logic [fpsc_pkg::SET_W-1:0]        right_set,
   input  logic [fpsc_pkg::WEIGHT_W-1:0]     site_weight,
   input  logic                              last_site,
   output logic [fpsc_pkg::SET_W-1:0]        node_set,
   output logic                              mutation_counted,
   output logic [fpsc_pkg::OUT_COST_W-1:0]   total_cost,
   output logic [COST_BITS-1:0]              cost_next,
   output fpsc_pkg::hist_type                hist_next
);
   import fpsc_pkg::*;

   localparam int SUM_W  = ((COST_BITS > WEIGHT_W) ? COST_BITS : WEIGHT_W) + 1;
   localparam int WIDE_W = (COST_BITS > OUT_COST_W) ? COST_BITS : OUT_COST_W;

   logic                 lg;
   logic                 rg;
   logic                 disjoint;
   logic [SET_W-1:0]     raw_set;
   logic                 skip;
   logic                 strip;
   logic [WEIGHT_W-1:0]  addend;
   logic [SUM_W-1:0]     sum;
   logic [COST_BITS-1:0] sat_sum;
   logic [COST_BITS-1:0] cost_now;
   logic [WIDE_W-1:0]    cost_wide;

   always_comb begin
      lg       = left_set[GAP_IDX];
      rg       = right_set[GAP_IDX];
      disjoint = ((left_set & right_set) == '0);
      raw_set  = disjoint ? (left_set | right_set) : (left_set & right_set);

      // gap carried on from the previous column in the same child
      skip = disjoint && cfg.merge_gap_runs && raw_set[GAP_IDX] && !hist.first_site &&
             hist.prev_node_gap &&
             ((lg && hist.prev_left_gap) || (rg && hist.prev_right_gap)) &&
             !(hist.prev_left_gap && hist.prev_right_gap);
      mutation_counted = disjoint && !skip;

      strip = !skip && cfg.strip_mixed_gaps && raw_set[GAP_IDX] &&
              (raw_set[GAP_IDX-1:0] != '0);
      node_set = strip ? {1'b0, raw_set[GAP_IDX-1:0]} : raw_set;

      addend  = cfg.use_weights ? site_weight : WEIGHT_W'(1);
      sum     = SUM_W'(cost) + SUM_W'(addend);
      // saturate when anything lands above the cost width
      sat_sum = (|sum[SUM_W-1:COST_BITS]) ? '1 : sum[COST_BITS-1:0];

      cost_now   = mutation_counted ? sat_sum : cost;
      cost_wide  = WIDE_W'(cost_now);
      total_cost = cost_wide[OUT_COST_W-1:0];
      cost_next  = last_site ? '0 : cost_now;

      hist_next.first_site     = last_site;
      hist_next.prev_node_gap  = node_set[GAP_IDX];
      hist_next.prev_left_gap  = lg;
      hist_next.prev_right_gap = rg;
   end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the fitch parsimony site combiner
`timescale 1ns / 100ps

module testbench;
   import fpsc_pkg::*;

   localparam int COST_BITS = 48;
   localparam logic [COST_BITS-1:0] COST_MAX = '1;
   localparam logic [SET_W-1:0] GAP_ONLY = SET_W'(1 << GAP_IDX);
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [SET_W-1:0]    left_set;
      logic [SET_W-1:0]    right_set;
      logic [WEIGHT_W-1:0] site_weight;
      logic                last_site;
   } site_word_type;

   typedef struct packed {
      logic [SET_W-1:0]      node_set;
      logic                  mutation_counted;
      logic [OUT_COST_W-1:0] total_cost;
      logic                  cost_final;
   } node_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fpsc_req_if req_ch ();
   fpsc_rsp_if rsp_ch ();

   fitch_parsimony_site_combine #(.COST_BITS(COST_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   cfg_type                reg_copy;
   hist_type               history;
   logic [COST_BITS-1:0]   cost_sum;

   site_word_type pending_sites [$];
   node_word_type expected_nodes [$];

   int  sites_issued;
   int  sites_accepted;
   int  results_seen;
   int  mismatches;
   int  mutations;
   int  gap_skips;
   int  saturated;
   int  sequences;
   int  send_idle;
   int  recv_idle;
   bit  req_taken;

   site_word_type directed_sites [13] = '{
      '{5'h01, 5'h02, 32'hFFFF_FFFF, 1'b0},
      '{5'h1F, 5'h1F, 32'h0000_0000, 1'b0},
      '{5'h10, 5'h00, 32'h0000_0005, 1'b0},   // empty right set
      '{5'h10, 5'h01, 32'h0000_0007, 1'b0},   // continued gap run
      '{5'h10, 5'h04, 32'h0000_0001, 1'b0},
      '{5'h10, 5'h10, 32'h0000_0003, 1'b0},
      '{5'h10, 5'h02, 32'h0000_0002, 1'b0},   // both had gap before: counted
      '{5'h01, 5'h10, 32'h0000_0009, 1'b1},
      '{5'h00, 5'h00, 32'hFFFF_FFFF, 1'b0},   // both sets empty
      '{5'h08, 5'h18, 32'h8000_0000, 1'b0},
      '{5'h1F, 5'h01, 32'h1234_5678, 1'b0},
      '{5'h10, 5'h0F, 32'hFFFF_FFFF, 1'b1},
      '{5'h04, 5'h08, 32'hFFFF_FFFF, 1'b1}    // one-column sequence
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic node_word_type combine_site(site_word_type w);
      logic [SET_W-1:0]   node;
      logic               lg;
      logic               rg;
      logic               skip;
      logic               counted;
      logic               same_seq;
      logic               not_both;
      logic [COST_BITS:0] addend;
      logic [COST_BITS:0] sum;
      node_word_type      res;
      lg = w.left_set[GAP_IDX];
      rg = w.right_set[GAP_IDX];
      skip = 1'b0;
      counted = 1'b0;
      if ((w.left_set & w.right_set) == '0) begin
         node = w.left_set | w.right_set;
         if (reg_copy.merge_gap_runs && node[GAP_IDX] && !history.first_site &&
             history.prev_node_gap) begin
            same_seq = (lg && history.prev_left_gap) || (rg && history.prev_right_gap);
            not_both = !history.prev_left_gap || !history.prev_right_gap;
            skip = same_seq && not_both;
         end
         if (skip) begin
            gap_skips++;
         end else begin
            counted = 1'b1;
            mutations++;
            addend = reg_copy.use_weights ? w.site_weight : 1;
            sum = {1'b0, cost_sum} + addend;
            cost_sum = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_BITS-1:0];
         end
      end else begin
         node = w.left_set & w.right_set;
      end
      // a skipped gap-run column keeps its gap bit
      if (!skip && reg_copy.strip_mixed_gaps && node[GAP_IDX] && node != GAP_ONLY)
         node[GAP_IDX] = 1'b0;
      if (cost_sum == COST_MAX)
         saturated++;
      res.node_set = node;
      res.mutation_counted = counted;
      res.total_cost = cost_sum[OUT_COST_W-1:0];
      res.cost_final = w.last_site;
      history.prev_node_gap = node[GAP_IDX];
      history.prev_left_gap = lg;
      history.prev_right_gap = rg;
      if (w.last_site) begin
         history.first_site = 1'b1;
         cost_sum = '0;
         sequences++;
      end else begin
         history.first_site = 1'b0;
      end
      return res;
   endfunction

   // one side of a column, with gap runs that persist over several columns
   function automatic logic [SET_W-1:0] side_set(inout bit in_run);
      int               pick;
      logic [SET_W-1:0] s;
      pick = $urandom_range(0, 99);
      if (in_run) begin
         if (pick < 55)
            s = GAP_ONLY;
         else if (pick < 75)
            s = GAP_ONLY | SET_W'($urandom_range(1, 15));
         else if (pick < 78)
            s = '0;
         else
            s = SET_W'($urandom_range(1, 15));
         if ($urandom_range(0, 99) < 25)
            in_run = 1'b0;
      end else begin
         if (pick < 70)
            s = SET_W'(1 << $urandom_range(0, 3));
         else if (pick < 97)
            s = SET_W'($urandom_range(1, 15));
         else
            s = SET_W'($urandom_range(1, 31));
         if ($urandom_range(0, 99) < 30)
            in_run = 1'b1;
      end
      return s;
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return WEIGHT_W'($urandom_range(1, 16));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic queue_site(input site_word_type w);
      pending_sites.push_back(w);
      sites_issued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_USE_WEIGHTS:      reg_copy.use_weights = val;
         CSR_MERGE_GAP_RUNS:   reg_copy.merge_gap_runs = val;
         CSR_STRIP_MIXED_GAPS: reg_copy.strip_mixed_gaps = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sites_accepted != sites_issued || results_seen != sites_accepted)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input bit uw, input bit mg, input bit st,
                            input int s_idle, input int r_idle, input int n_items);
      site_word_type words [$];
      site_word_type w;
      bit            lrun;
      bit            rrun;
      bit            noise;
      int            len;
      int            k;
      int            half;
      write_reg(CSR_USE_WEIGHTS, uw);
      write_reg(CSR_MERGE_GAP_RUNS, mg);
      write_reg(CSR_STRIP_MIXED_GAPS, st);
      lrun = 1'b0;
      rrun = 1'b0;
      while (words.size() < n_items) begin
         noise = ($urandom_range(0, 9) < 2);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            if (noise) begin
               w.left_set = SET_W'($urandom_range(0, 31));
               w.right_set = SET_W'($urandom_range(0, 31));
            end else begin
               w.left_set = side_set(lrun);
               w.right_set = side_set(rrun);
            end
            w.site_weight = pick_weight();
            w.last_site = (k == len - 1);
            words.push_back(w);
         end
      end
      // sender pauses midway until every result is back
      half = words.size() / 2;
      @(posedge clock);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (k = 0; k < half; k++)
         queue_site(words[k]);
      wait_drained();
      @(posedge clock);
      for (k = half; k < words.size(); k++)
         queue_site(words[k]);
      wait_drained();
   endtask

   // driver: hold the word until taken
   always @(negedge clock) begin
      if (req_taken && pending_sites.size() != 0)
         void'(pending_sites.pop_front());
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_sites.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req_ch.valid <= 1'b1;
            req_ch.left_set <= pending_sites[0].left_set;
            req_ch.right_set <= pending_sites[0].right_set;
            req_ch.site_weight <= pending_sites[0].site_weight;
            req_ch.last_site <= pending_sites[0].last_site;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   // monitor: check result words, then predict from accepted site words
   always @(posedge clock) begin
      node_word_type got;
      node_word_type want;
      site_word_type word;
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.node_set = rsp_ch.node_set;
         got.mutation_counted = rsp_ch.mutation_counted;
         got.total_cost = rsp_ch.total_cost;
         got.cost_final = rsp_ch.cost_final;
         results_seen++;
         if (expected_nodes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result word with none expected: set %h cnt %b cost %h fin %b",
                        $realtime, got.node_set, got.mutation_counted, got.total_cost,
                        got.cost_final);
         end else begin
            want = expected_nodes.pop_front();
            if (got.node_set !== want.node_set ||
                got.mutation_counted !== want.mutation_counted ||
                got.total_cost !== want.total_cost ||
                got.cost_final !== want.cost_final) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch exp %h/%b/%h/%b got %h/%b/%h/%b",
                           $realtime, want.node_set, want.mutation_counted, want.total_cost,
                           want.cost_final, got.node_set, got.mutation_counted,
                           got.total_cost, got.cost_final);
            end
         end
      end
      if (req_taken) begin
         word.left_set = req_ch.left_set;
         word.right_set = req_ch.right_set;
         word.site_weight = req_ch.site_weight;
         word.last_site = req_ch.last_site;
         expected_nodes.push_back(combine_site(word));
         sites_accepted++;
      end
   end

   initial begin
      int p;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.left_set = '0;
      req_ch.right_set = '0;
      req_ch.site_weight = '0;
      req_ch.last_site = 1'b0;
      rsp_ch.ready = 1'b0;
      reg_copy = '{use_weights: 1'b0, merge_gap_runs: 1'b1, strip_mixed_gaps: 1'b1};
      history = HIST_RESET;
      cost_sum = '0;
      send_idle = 0;
      recv_idle = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed columns under the reset settings, then with every rule flipped
      @(posedge clock);
      send_idle = 26;
      recv_idle = 71;
      foreach (directed_sites[i])
         queue_site(directed_sites[i]);
      wait_drained();
      write_reg(CSR_USE_WEIGHTS, 1'b1);
      write_reg(CSR_MERGE_GAP_RUNS, 1'b0);
      write_reg(CSR_STRIP_MIXED_GAPS, 1'b0);
      @(posedge clock);
      foreach (directed_sites[i])
         queue_site(directed_sites[i]);
      wait_drained();

      for (p = 0; p < 8; p++) begin
         if (p < 3)
            run_phase(p[0], p[1], p[2], 26, 71, 100);
         else if (p < 6)
            run_phase(p[0], p[1], p[2], 71, 26, 100);
         else
            run_phase(p[0], p[1], p[2], 0, 0, 100);
      end

      repeat (10) @(negedge clock);
      $display("checked %0d result words over %0d sequences, all eight register settings",
               results_seen, sequences);
      $display("%0d mutations counted, %0d gap-run columns skipped, %0d saturated costs",
               mutations, gap_skips, saturated);
      if (mismatches == 0 && expected_nodes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_nodes.size());
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", sites_issued - results_seen);
      $display("FAILURE");
      $finish;
   end

endmodule
